[rtl/torus_flitwise_router_node_top_macros.svh]
// Assertion macros for the torus router node.
// Included by torus_flitwise_router_node_top; no other dependencies.
`ifndef TORUS_FLITWISE_ROUTER_NODE_TOP_MACROS_SVH
`define TORUS_FLITWISE_ROUTER_NODE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define TFRN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define TFRN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFRN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TFRN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/tfrn_pkg.sv]
// Types, constants and helpers for the torus router node.
// No dependencies; imported by torus_flitwise_router_node_top.
package tfrn_pkg;

    localparam int MAX_WIDTH    = 16;
    localparam int CORNER_DEPTH = 4;
    localparam int PAYLOAD_BITS = 32;

    localparam int COL_W  = 4;
    localparam int RW_W   = 5;
    localparam int TIDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PTR_W  = (CORNER_DEPTH > 1) ? $clog2(CORNER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(CORNER_DEPTH + 1);
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [RW_W-1:0] RING_WIDTH_RST = RW_W'(4);

    localparam logic [1:0] REG_NODE_COLUMN = 2'd0;
    localparam logic [1:0] REG_NODE_ROW    = 2'd1;
    localparam logic [1:0] REG_RING_WIDTH  = 2'd2;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [COL_W-1:0]        src_row;
        logic [COL_W-1:0]        src_col;
        logic [COL_W-1:0]        dest_row;
        logic [COL_W-1:0]        dest_col;
        logic                    marked;
        logic                    valid;
    } t_flit;

    typedef struct packed {
        t_flit west_flit;
        t_flit south_flit;
        t_flit core_flit;
        logic  signaled_east;
        logic  signaled_north;
    } t_rtr_in;

    typedef struct packed {
        t_flit north_flit;
        t_flit east_flit;
        t_flit eject_flit;
        logic  core_taken;
        logic  signal_west;
        logic  signal_south;
    } t_rtr_out;

    function automatic logic col_in_range(input logic [COL_W-1:0] col);
        return ({1'b0, col} < (COL_W+1)'(MAX_WIDTH));
    endfunction

    function automatic logic [TIDX_W-1:0] col_idx(input logic [COL_W-1:0] col);
        return TIDX_W'(col);
    endfunction

endpackage

[rtl/torus_flitwise_router_node_top.sv]
// Torus router node: one bufferless slotted node with corner FIFO and block timers.
// Depends on tfrn_pkg and torus_flitwise_router_node_top_macros.svh.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall, payload i_in) carries one network
//   cycle's worth of node inputs: west, south and core flits plus the east and
//   north slot requests. Output channel (o_out_valid / i_out_stall, payload
//   o_out) carries the north, east and eject flits, core_taken, and the west
//   and south slot requests for that cycle.
// - A request lands in the input register, the routing logic runs on it there
//   and its result is captured in the output register, updating the FIFO,
//   timers and flags at the same edge.
// - Throughput is one request per cycle while the receiver does not stall; the
//   routing decision and all state updates are a single combinational pass, so nothing recirculates.
// - When the receiver stalls, the output register holds and the input register
//   fills; once both are full o_in_stall rises until the output drains.
// - Reset clears both pipeline valid flags, the FIFO count and pointer, all
//   block timers and counters, both sent flags, and loads the configuration
//   defaults (column 0, row 0, ring width 4). FIFO entries need no clearing.
// - Configuration registers (APB, byte address 4*i) are written while idle by the user; the block does not check.
`include "torus_flitwise_router_node_top_macros.svh"

module torus_flitwise_router_node_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tfrn_pkg::t_rtr_in                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tfrn_pkg::t_rtr_out                 o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfrn_pkg::ADDR_W-1:0]        paddr,
    input  logic [tfrn_pkg::DATA_W-1:0]        pwdata,
    output logic [tfrn_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import tfrn_pkg::*;

    // configuration
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_row;
    logic [RW_W-1:0]  r_rw;

    // pipeline
    logic     r_in_valid;
    t_rtr_in  r_in;
    logic     r_out_valid;
    t_rtr_out r_out;
    logic     adv;
    logic     upd;
    logic     out_hold;
    logic     eject_here;

    // routing state
    t_flit            r_fifo [CORNER_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [RW_W-1:0]  r_tmr [MAX_WIDTH];
    logic [RW_W-1:0]  r_sb;
    logic [RW_W-1:0]  r_rb;
    logic             r_sent_n;
    logic             r_sent_e;

    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] n_count;
    logic [RW_W-1:0]  n_tmr [MAX_WIDTH];
    logic [RW_W-1:0]  n_sb;
    logic [RW_W-1:0]  n_rb;
    logic             n_sent_n;
    logic             n_sent_e;
    t_rtr_out         n_out;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    t_flit            wr_data;

    logic [1:0] reg_idx;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_NODE_COLUMN: prdata = DATA_W'(r_col);
            REG_NODE_ROW:    prdata = DATA_W'(r_row);
            REG_RING_WIDTH:  prdata = DATA_W'(r_rw);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rw  <= RING_WIDTH_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_NODE_COLUMN: r_col <= pwdata[COL_W-1:0];
                REG_NODE_ROW:    r_row <= pwdata[COL_W-1:0];
                REG_RING_WIDTH:  r_rw  <= pwdata[RW_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register parts the two sides.
    assign adv         = !r_out_valid || !i_out_stall;
    assign upd         = r_in_valid && adv;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (adv) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) r_in <= i_in;
        if (upd) r_out <= n_out;
        if (upd && wr_en) r_fifo[wr_addr] <= wr_data;
    end

    // Routing pass
    always_comb begin
        t_flit w, s, c, north, east, eject;
        logic in_w, in_s, in_c, s_me, w_me, sig_n_blk, full, own_col_busy, busy_c;
        logic has_north, has_east, has_eject, w_to_corner;
        logic push_w, delay_w, push_c, delay_c, push_d, pop;
        logic taken, sig_w, sig_s, core_held;
        logic [MAX_WIDTH-1:0] ld;
        logic [RW_W-1:0] sb_mid, rb_mid, t;
        logic [CNT_W:0] sum;
        w = r_in.west_flit;
        s = r_in.south_flit;
        c = r_in.core_flit;
        in_w = w.valid;
        in_s = s.valid;
        in_c = c.valid;
        sig_n_blk = r_in.signaled_north && r_sent_n;
        full = (r_count == CNT_W'(CORNER_DEPTH));
        own_col_busy = col_in_range(r_col) && (r_tmr[col_idx(r_col)] != '0);
        ld = '0;
        sb_mid = r_sb;
        rb_mid = r_rb;
        north = '0;
        east = '0;
        eject = '0;
        has_east = 1'b0;
        w_to_corner = 1'b0;
        push_w = 1'b0;
        delay_w = 1'b0;
        push_c = 1'b0;
        delay_c = 1'b0;
        push_d = 1'b0;
        pop = 1'b0;
        taken = 1'b0;
        sig_w = 1'b0;
        sig_s = 1'b0;
        n_sent_e = r_sent_e;
        n_sent_n = r_sent_n;

        // Marked flits block their column; own flits returning block sending.
        if (in_w) begin
            if (w.marked && (w.dest_col != r_col) && col_in_range(w.dest_col))
                ld[col_idx(w.dest_col)] = 1'b1;
            if ((w.src_col == r_col) && (w.src_row == r_row))
                sb_mid = r_rw;
        end

        s_me = (s.dest_col == r_col) && (s.dest_row == r_row);
        has_eject = in_s && s_me;
        has_north = in_s && !s_me;
        if (has_eject) eject = s;
        if (has_north) north = s;

        w_me = (w.dest_col == r_col) && (w.dest_row == r_row);
        if (in_w) begin
            if (own_col_busy) begin
                if (w_me && !has_eject && (r_rb == '0)) begin
                    eject = w;
                    has_eject = 1'b1;
                end else begin
                    east = w;
                    has_east = 1'b1;
                end
            end else if (w_me) begin
                if (!has_eject && (r_rb == '0)) begin
                    eject = w;
                    has_eject = 1'b1;
                end else begin
                    if (r_rb == '0) rb_mid = r_rw;
                    east = w;
                    has_east = 1'b1;
                end
            end else if (w.dest_col == r_col) begin
                if (!full) begin
                    push_w = 1'b1;
                    w_to_corner = 1'b1;
                end else if (!has_north && !sig_n_blk) begin
                    delay_w = 1'b1;
                    w_to_corner = 1'b1;
                end else begin
                    // Corner full: mark and send round the ring.
                    east = w;
                    east.marked = 1'b1;
                    has_east = 1'b1;
                    if (col_in_range(r_col)) ld[col_idx(r_col)] = 1'b1;
                end
            end else begin
                east = w;
                has_east = 1'b1;
            end
        end

        busy_c = col_in_range(c.dest_col) &&
                 (ld[col_idx(c.dest_col)] ? (r_rw != '0)
                                          : (r_tmr[col_idx(c.dest_col)] != '0));
        core_held = (c.dest_row == r_row) ? (sb_mid != '0) : busy_c;

        if (in_c) begin
            if (c.dest_col == r_col) begin
                if (!own_col_busy && !w_to_corner) begin
                    if (!full) begin
                        push_c = 1'b1;
                        taken = 1'b1;
                    end else if (!delay_w && !sig_n_blk) begin
                        delay_c = 1'b1;
                    end else begin
                        sig_w = 1'b1;
                    end
                end
            end else if (core_held) begin
                if (!has_east) n_sent_e = 1'b0;
            end else if (has_east) begin
                // Never overwrite an east slot already taken by a west flit.
                sig_w = 1'b1;
            end else if (r_in.signaled_east && r_sent_e) begin
                n_sent_e = 1'b0;
                sig_w = 1'b1;
            end else begin
                east = c;
                has_east = 1'b1;
                taken = 1'b1;
                n_sent_e = 1'b1;
            end
        end else if (!has_east) begin
            n_sent_e = 1'b0;
        end else if (r_in.signaled_east) begin
            sig_w = 1'b1;
        end

        // Corner head leaves north; a flit pushed this cycle is never eligible.
        if (r_count != '0) begin
            if (has_north) begin
                sig_s = 1'b1;
            end else if (sig_n_blk) begin
                n_sent_n = 1'b0;
            end else begin
                pop = 1'b1;
                north = r_fifo[r_head];
                n_sent_n = 1'b1;
                if (delay_w) begin
                    push_d = 1'b1;
                end else if (delay_c) begin
                    push_d = 1'b1;
                    taken = 1'b1;
                end
            end
        end else begin
            if (!has_north) n_sent_n = 1'b0;
            else if (r_in.signaled_north) sig_s = 1'b1;
        end

        // At most one write per pass; tail slot is head+count in both cases.
        wr_en = push_w || push_c || push_d;
        wr_data = (push_w || delay_w) ? w : c;
        sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
        if (sum >= (CNT_W+1)'(CORNER_DEPTH)) sum = sum - (CNT_W+1)'(CORNER_DEPTH);
        wr_addr = PTR_W'(sum);

        if (pop) begin
            n_head = (r_head == PTR_W'(CORNER_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end else begin
            n_head = r_head;
        end
        n_count = r_count + CNT_W'(wr_en) - CNT_W'(pop);

        for (int i = 0; i < MAX_WIDTH; i++) begin
            t = ld[i] ? r_rw : r_tmr[i];
            n_tmr[i] = (t != '0) ? t - 1'b1 : '0;
        end
        n_sb = (sb_mid != '0) ? sb_mid - 1'b1 : '0;
        n_rb = (rb_mid != '0) ? rb_mid - 1'b1 : '0;

        n_out.north_flit   = north;
        n_out.east_flit    = east;
        n_out.eject_flit   = eject;
        n_out.core_taken   = taken;
        n_out.signal_west  = sig_w;
        n_out.signal_south = sig_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_sb     <= '0;
            r_rb     <= '0;
            r_sent_n <= 1'b0;
            r_sent_e <= 1'b0;
            for (int i = 0; i < MAX_WIDTH; i++) r_tmr[i] <= '0;
        end else if (upd) begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_sb     <= n_sb;
            r_rb     <= n_rb;
            r_sent_n <= n_sent_n;
            r_sent_e <= n_sent_e;
            for (int i = 0; i < MAX_WIDTH; i++) r_tmr[i] <= n_tmr[i];
        end
    end

    assign out_hold   = o_out_valid && i_out_stall;
    assign eject_here = (r_out.eject_flit.dest_col == r_col) &&
                        (r_out.eject_flit.dest_row == r_row);

    `TFRN_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CORNER_DEPTH))
    `TFRN_ASSERT_IMP(a_eject_local, i_clk, i_rst_n, o_out_valid && o_out.eject_flit.valid, eject_here)
    `TFRN_ASSERT_IMP(a_full_stalls, i_clk, i_rst_n, r_in_valid && out_hold, o_in_stall)
    `TFRN_ASSERT_NXT(a_bubble_drains, i_clk, i_rst_n, !r_in_valid && !out_hold, !o_out_valid)

endmodule
